### rtl/vwi_pkg.sv
`default_nettype none

package vwi_pkg;

  // Table depth default and fixed field widths
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_W          = 32;
  localparam int IDX_OUT_W        = 10;
  localparam int TOL_W            = 40;

  // Distance arithmetic: a component difference of 2^21 or more never matches
  localparam int MAG_W = 21;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;

  // Packed coordinate word in the vertex table: {x, y, z}
  localparam int VTX_W = 3 * COORD_W;

  // Configuration port
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_STRIP_MODE   = 1'b0;
  localparam logic REG_TOLERANCE_SQ = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 40'd43;

  typedef struct packed {
    logic             strip_mode;
    logic [TOL_W-1:0] tolerance_sq;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } match_stat_t;

endpackage

`default_nettype wire

### rtl/vwi_if.sv
`default_nettype none

interface vwi_in_if import vwi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic                      mesh_start;

  modport source (output valid, coord_x, coord_y, coord_z, mesh_start, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, mesh_start, output ready);
endinterface

interface vwi_out_if import vwi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] vertex_index;
  logic                 is_new;
  logic                 tri_valid;
  logic [IDX_OUT_W-1:0] tri_first;
  logic [IDX_OUT_W-1:0] tri_second;
  logic [IDX_OUT_W-1:0] tri_third;
  logic                 overflow;

  modport source (output valid, vertex_index, is_new, tri_valid, tri_first, tri_second,
                  tri_third, overflow, input ready);
  modport sink   (input valid, vertex_index, is_new, tri_valid, tri_first, tri_second,
                  tri_third, overflow, output ready);
endinterface

`default_nettype wire

### rtl/vwi_ram.sv
`default_nettype none

module vwi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/vwi_cfg.sv
`default_nettype none

module vwi_cfg import vwi_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic             strip_mode_r, strip_mode_nxt;
  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[REG_SEL_BIT];

  // Register write decode
  always_comb begin
    strip_mode_nxt = strip_mode_r;
    tol_nxt        = tol_r;
    if (wr_en) begin
      case (reg_sel)
        REG_STRIP_MODE:   strip_mode_nxt = pwdata[0];
        REG_TOLERANCE_SQ: tol_nxt        = pwdata[TOL_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_mode_r <= 1'b0;
      tol_r        <= TOL_RESET;
    end else begin
      strip_mode_r <= strip_mode_nxt;
      tol_r        <= tol_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_STRIP_MODE:   prdata = {{(APB_DATA_W-1){1'b0}}, strip_mode_r};
      REG_TOLERANCE_SQ: prdata = {{(APB_DATA_W-TOL_W){1'b0}}, tol_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.strip_mode   = strip_mode_r;
  assign cfg.tolerance_sq = tol_r;

endmodule

`default_nettype wire

### rtl/vwi_match.sv
`default_nettype none

// Three-stage distance pipeline: magnitude, square, sum and compare.
module vwi_match import vwi_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            flush,
  input  wire logic                            in_vld,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] in_idx,
  input  wire logic [VTX_W-1:0]                entry,
  input  wire logic [COORD_W-1:0]              item_x,
  input  wire logic [COORD_W-1:0]              item_y,
  input  wire logic [COORD_W-1:0]              item_z,
  input  wire logic [TOL_W-1:0]                tolerance_sq,
  output match_stat_t                          stat,
  output logic      [$clog2(MAX_VERTICES)-1:0] hit_idx
);

  localparam int IW = $clog2(MAX_VERTICES);

  logic [COORD_W-1:0] ent_c  [3];
  logic [COORD_W-1:0] item_c [3];
  logic [MAG_W-1:0]   mag    [3];
  logic [2:0]         near;

  logic [MAG_W-1:0] mag1_r [3];
  logic             ok1_r, vld1_r, vld1_nxt;
  logic [IW-1:0]    idx1_r;
  logic [SQ_W-1:0]  sq2_r  [3];
  logic             ok2_r, vld2_r, vld2_nxt;
  logic [IW-1:0]    idx2_r;
  logic [SUM_W-1:0] sum;
  logic             hit3_r, vld3_r, vld3_nxt;
  logic [IW-1:0]    idx3_r;

  assign ent_c[0]  = entry[VTX_W-1 -: COORD_W];
  assign ent_c[1]  = entry[VTX_W-COORD_W-1 -: COORD_W];
  assign ent_c[2]  = entry[COORD_W-1:0];
  assign item_c[0] = item_x;
  assign item_c[1] = item_y;
  assign item_c[2] = item_z;

  // Exact signed difference per axis, magnitude and range check
  always_comb begin
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    for (int i = 0; i < 3; i++) begin
      d       = {ent_c[i][COORD_W-1], ent_c[i]} - {item_c[i][COORD_W-1], item_c[i]};
      m       = d[COORD_W] ? (~d + 1'b1) : d;
      mag[i]  = m[MAG_W-1:0];
      near[i] = (m[COORD_W:MAG_W] == '0);
    end
  end

  // Drop in-flight comparisons on flush
  assign vld1_nxt = in_vld & ~flush;
  assign vld2_nxt = vld1_r & ~flush;
  assign vld3_nxt = vld2_r & ~flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= vld1_nxt;
      vld2_r <= vld2_nxt;
      vld3_r <= vld3_nxt;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1_r[i] <= mag[i];
      sq2_r[i]  <= mag1_r[i] * mag1_r[i];
    end
    ok1_r  <= &near;
    idx1_r <= in_idx;
    ok2_r  <= ok1_r;
    idx2_r <= idx1_r;
    hit3_r <= ok2_r & (sum < {{(SUM_W-TOL_W){1'b0}}, tolerance_sq});
    idx3_r <= idx2_r;
  end

  assign sum = {2'b00, sq2_r[0]} + {2'b00, sq2_r[1]} + {2'b00, sq2_r[2]};

  assign stat.busy = vld1_r | vld2_r | vld3_r;
  assign stat.hit  = vld3_r & hit3_r;
  assign hit_idx   = idx3_r;

endmodule

`default_nettype wire

### rtl/vertex_weld_indexer.sv
`default_nettype none

// Vertex welding indexer. Each input transaction carries one Q16.16 vertex; the
// block scans its table of unique vertices, one entry per cycle through the
// single read port of the vertex RAM, and returns the index of the first entry
// within the squared tolerance, or appends the vertex and flags it new. On a
// miss every stored entry is compared; on a hit the scan stops at the match.
// Reads are issued back to back, so the RAM read and the three register stages
// of the distance pipeline are passed through once per item, not once per
// entry. An item that needs no scan (empty table, or the first two vertices of
// a strip) goes straight from idle to the done state. A result left waiting on
// the output holds the block. Strip mode forms one triangle per vertex from the
// third on, with alternating winding and a validity flag for non-degenerate
// triangles. A full table reports overflow with index 0 and stores nothing.
// Configuration must be written only while idle; the block itself does not
// enforce this.
module vertex_weld_indexer import vwi_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  vwi_in_if.sink                     in_if,
  vwi_out_if.source                  out_if,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  function automatic logic [IDX_OUT_W-1:0] out_idx(input logic [IW-1:0] v);
    logic [IW+IDX_OUT_W-1:0] e;
    e = {{IDX_OUT_W{1'b0}}, v};
    return e[IDX_OUT_W-1:0];
  endfunction

  cfg_t        cfg;
  match_stat_t mstat;
  logic [IW-1:0] hit_idx;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          issue_vld_r, issue_vld_nxt;
  logic [IW-1:0] issue_idx_r;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] older_r, older_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic [COORD_W-1:0] x_r, y_r, z_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0] vidx_r, tri_a_r, tri_b_r, tri_c_r;
  logic                 is_new_r, tri_valid_r, overflow_r;

  logic          in_acc;
  logic          issuing;
  logic          finish;
  logic          full;
  logic          append;
  logic          ram_we;
  logic [IW-1:0] sel_idx;
  logic [IW-1:0] ta, tb, tc;
  logic          tri_on;
  logic [VTX_W-1:0] rdata;

  vwi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vwi_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata ({x_r, y_r, z_r}),
    .re    (issuing),
    .raddr (issue_r[IW-1:0]),
    .rdata (rdata)
  );

  vwi_match #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_match (
    .clk          (clk),
    .rst_n        (rst_n),
    .flush        (state_r != S_SCAN),
    .in_vld       (issue_vld_r),
    .in_idx       (issue_idx_r),
    .entry        (rdata),
    .item_x       (x_r),
    .item_y       (y_r),
    .item_z       (z_r),
    .tolerance_sq (cfg.tolerance_sq),
    .stat         (mstat),
    .hit_idx      (hit_idx)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;
  assign issuing     = (state_r == S_SCAN) & (issue_r != count_r) & ~mstat.hit;
  assign finish      = (state_r == S_DONE) & (~out_valid_r | out_if.ready);

  // Resolve the item: match, append or overflow, and the strip triangle
  assign full    = (count_r == CW'(MAX_VERTICES));
  assign append  = ~found_r;
  assign ram_we  = finish & append & ~full;
  assign sel_idx = found_r ? fidx_r : count_r[IW-1:0];
  assign tri_on  = cfg.strip_mode & pos_r[1];
  assign ta      = older_r;
  assign tb      = pos_r[0] ? sel_idx : prev_r;
  assign tc      = pos_r[0] ? prev_r : sel_idx;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    issue_vld_nxt = issuing;
    prev_nxt      = prev_r;
    older_nxt     = older_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          found_nxt = 1'b0;
          issue_nxt = '0;
          if (in_if.mesh_start) begin
            count_nxt = '0;
            prev_nxt  = '0;
            older_nxt = '0;
            pos_nxt   = '0;
          end
          // Skip the scan for an empty table or the strip's first two vertices
          if ((cfg.strip_mode && !pos_nxt[1]) || count_nxt == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issuing) begin
          issue_nxt = issue_r + CW'(1);
        end
        if (mstat.hit) begin
          found_nxt = 1'b1;
          fidx_nxt  = hit_idx;
          state_nxt = S_DONE;
        end else if (issue_r == count_r && !issue_vld_r && !mstat.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          state_nxt = S_IDLE;
          if (!(append && full)) begin
            if (append) begin
              count_nxt = count_r + CW'(1);
            end
            if (cfg.strip_mode) begin
              older_nxt = prev_r;
              prev_nxt  = sel_idx;
              pos_nxt   = (pos_r == 2'd3) ? 2'd2 : pos_r + 2'd1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_if.ready;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      issue_vld_r <= 1'b0;
      prev_r      <= '0;
      older_r     <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      issue_vld_r <= issue_vld_nxt;
      prev_r      <= prev_nxt;
      older_r     <= older_nxt;
      pos_r       <= pos_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    fidx_r      <= fidx_nxt;
    issue_idx_r <= issue_r[IW-1:0];
    if (in_acc) begin
      x_r <= in_if.coord_x;
      y_r <= in_if.coord_y;
      z_r <= in_if.coord_z;
    end
    if (finish) begin
      if (append && full) begin
        vidx_r      <= '0;
        is_new_r    <= 1'b0;
        tri_valid_r <= 1'b0;
        tri_a_r     <= '0;
        tri_b_r     <= '0;
        tri_c_r     <= '0;
        overflow_r  <= 1'b1;
      end else begin
        vidx_r      <= out_idx(sel_idx);
        is_new_r    <= append;
        tri_valid_r <= tri_on & (ta != tb) & (tb != tc) & (tc != ta);
        tri_a_r     <= tri_on ? out_idx(ta) : '0;
        tri_b_r     <= tri_on ? out_idx(tb) : '0;
        tri_c_r     <= tri_on ? out_idx(tc) : '0;
        overflow_r  <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.vertex_index = vidx_r;
  assign out_if.is_new       = is_new_r;
  assign out_if.tri_valid    = tri_valid_r;
  assign out_if.tri_first    = tri_a_r;
  assign out_if.tri_second   = tri_b_r;
  assign out_if.tri_third    = tri_c_r;
  assign out_if.overflow     = overflow_r;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
  import vwi_pkg::*;

  // Shallow table so that full-table behaviour is reached in a short run
  localparam int TABLE_DEPTH = 64;

  localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};
  localparam logic [APB_ADDR_W-1:0] ADDR_STRIP = APB_ADDR_W'(REG_STRIP_MODE) << REG_SEL_BIT;
  localparam logic [APB_ADDR_W-1:0] ADDR_TOL   = APB_ADDR_W'(REG_TOLERANCE_SQ) << REG_SEL_BIT;

  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 25;
  localparam int TAIL_CYCLES = TABLE_DEPTH + 20;

  typedef logic [2:0][COORD_W-1:0] coords_t;   // {x, y, z}

  typedef struct packed {
    logic    mesh_start;
    coords_t pos;
  } vertex_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] vertex_index;
    logic                 is_new;
    logic                 tri_valid;
    logic [IDX_OUT_W-1:0] tri_first;
    logic [IDX_OUT_W-1:0] tri_second;
    logic [IDX_OUT_W-1:0] tri_third;
    logic                 overflow;
  } weld_result_t;

  // Typed-in expectation travelling with a transaction until it is accepted
  typedef struct packed {
    logic         typed;
    weld_result_t res;
  } stim_tag_t;

  typedef struct packed {
    logic                 strip;
    logic [TOL_W-1:0]     tol;
    logic                 mesh_start;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;
    logic                 typed;
    logic [IDX_OUT_W-1:0] exp_index;
    logic                 exp_new;
  } directed_row_t;

  // Directed rows: extremes, exact and near matches, tolerance edges, strip winding
  localparam directed_row_t DIRECTED_ROWS [24] = '{
    '{1'b0, 40'd43, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 10'd0, 1'b1},
    '{1'b0, 40'd43, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 10'd0, 1'b0},
    '{1'b0, 40'd43, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 10'd1, 1'b1},
    '{1'b0, 40'd43, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 10'd2, 1'b1},
    '{1'b0, 40'd43, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 10'd3, 1'b1},
    '{1'b0, 40'd43, 1'b0, 32'h0000_0006, 32'h0000_0001, 32'h0000_0001, 1'b1, 10'd0, 1'b0},
    '{1'b0, 40'd43, 1'b0, 32'h0000_0006, 32'h0000_0002, 32'h0000_0002, 1'b0, 10'd0, 1'b0},
    '{1'b0, 40'd43, 1'b0, 32'h0000_0005, 32'h0000_0003, 32'h0000_0003, 1'b0, 10'd0, 1'b0},
    '{1'b0, 40'd43, 1'b0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 10'd0, 1'b0},
    '{1'b0, 40'd43, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0, 10'd0, 1'b0},
    '{1'b1, 40'd43, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 10'd0, 1'b1},
    '{1'b1, 40'd43, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 10'd1, 1'b1},
    '{1'b1, 40'd43, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0, 1'b0},
    '{1'b1, 40'd43, 1'b0, 32'h0001_86A0, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0, 1'b0},
    '{1'b1, 40'd43, 1'b0, 32'h0003_0D40, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0, 1'b0},
    '{1'b1, 40'd43, 1'b0, 32'h0003_0D40, 32'h0000_0000, 32'h0000_0001, 1'b0, 10'd0, 1'b0},
    '{1'b1, 40'd0,  1'b1, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b1, 10'd0, 1'b1},
    '{1'b1, 40'd0,  1'b0, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b1, 10'd1, 1'b1},
    '{1'b1, 40'd0,  1'b0, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b0, 10'd0, 1'b0},
    '{1'b0, TOL_MAX, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 10'd0, 1'b1},
    '{1'b0, TOL_MAX, 1'b0, 32'h000F_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0, 1'b0},
    '{1'b0, TOL_MAX, 1'b0, 32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0, 1'b0},
    '{1'b0, TOL_MAX, 1'b0, 32'h000F_FFFF, 32'h000F_FFFF, 32'h0000_0000, 1'b0, 10'd0, 1'b0},
    '{1'b0, TOL_MAX, 1'b0, 32'h001F_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  vwi_in_if  in_if();
  vwi_out_if out_if();

  vertex_weld_indexer #(.MAX_VERTICES(TABLE_DEPTH)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the welding table and strip state
  coords_t          weld_table [TABLE_DEPTH];
  int unsigned      weld_count = 0;
  int unsigned      prev_vertex = 0;
  int unsigned      older_vertex = 0;
  logic [1:0]       strip_pos = 2'd0;
  logic             pred_strip = 1'b0;
  logic [TOL_W-1:0] pred_tol = TOL_RESET;

  stim_tag_t    stim_tags [$];
  weld_result_t awaited_results [$];
  int           mismatch_count = 0;
  int           result_count = 0;

  // Stimulus-side controls
  int      idle_pct = 0;
  bit      stall_on = 1'b0;
  int      stall_left = 0;
  logic    drv_strip = 1'b0;
  logic [TOL_W-1:0] drv_tol = TOL_RESET;
  coords_t mesh_hist [$];

  // Weld one vertex into the predictor table and form the strip triangle
  function automatic weld_result_t weld_predict(input vertex_t v);
    weld_result_t     r;
    bit               hit;
    bit               near;
    int unsigned      idx;
    int unsigned      k;
    int unsigned      a;
    int unsigned      b;
    int unsigned      c;
    int               axis;
    logic [32:0]      diff;
    logic [32:0]      mag;
    logic [63:0]      sq_sum;
    r   = '0;
    hit = 1'b0;
    idx = 0;
    if (v.mesh_start) begin
      weld_count   = 0;
      prev_vertex  = 0;
      older_vertex = 0;
      strip_pos    = 2'd0;
    end
    // Scan in table order; the first entry strictly inside the tolerance wins
    if (!(pred_strip && strip_pos < 2'd2)) begin
      for (k = 0; k < weld_count && !hit; k++) begin
        near   = 1'b1;
        sq_sum = '0;
        for (axis = 0; axis < 3; axis++) begin
          diff = {weld_table[k][axis][COORD_W-1], weld_table[k][axis]} -
                 {v.pos[axis][COORD_W-1], v.pos[axis]};
          mag  = diff[32] ? -diff : diff;
          if (mag >= 33'(1) << MAG_W) near = 1'b0;
          else sq_sum = sq_sum + 64'(mag) * 64'(mag);
        end
        if (near && sq_sum < 64'(pred_tol)) begin
          hit = 1'b1;
          idx = k;
        end
      end
    end
    if (!hit) begin
      // Full table: report overflow and leave all state alone
      if (weld_count >= TABLE_DEPTH) begin
        r.overflow = 1'b1;
        return r;
      end
      idx = weld_count;
      weld_table[idx] = v.pos;
      weld_count++;
      r.is_new = 1'b1;
    end
    r.vertex_index = IDX_OUT_W'(idx);
    if (pred_strip) begin
      if (strip_pos >= 2'd2) begin
        a = older_vertex;
        if (strip_pos[0]) begin
          b = idx;
          c = prev_vertex;
        end else begin
          b = prev_vertex;
          c = idx;
        end
        r.tri_valid  = (a != b) && (b != c) && (c != a);
        r.tri_first  = IDX_OUT_W'(a);
        r.tri_second = IDX_OUT_W'(b);
        r.tri_third  = IDX_OUT_W'(c);
      end
      older_vertex = prev_vertex;
      prev_vertex  = idx;
      strip_pos    = (strip_pos < 2'd3) ? strip_pos + 2'd1 : 2'd2;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  // Track register writes, predict accepted vertices, check accepted results
  always @(posedge clk) begin
    vertex_t      v;
    stim_tag_t    tag;
    weld_result_t got;
    weld_result_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_STRIP) pred_strip = pwdata[0];
        else if (paddr == ADDR_TOL) pred_tol = pwdata[TOL_W-1:0];
      end
      if (in_if.valid && in_if.ready) begin
        v.mesh_start = in_if.mesh_start;
        v.pos = {in_if.coord_x, in_if.coord_y, in_if.coord_z};
        tag  = stim_tags.pop_front();
        want = weld_predict(v);
        awaited_results.insert(awaited_results.size(), tag.typed ? tag.res : want);
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.vertex_index, out_if.is_new, out_if.tri_valid, out_if.tri_first,
                out_if.tri_second, out_if.tri_third, out_if.overflow};
        result_count++;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(got), 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (got.vertex_index !== want.vertex_index)
            report_mismatch("vertex_index", 64'(got.vertex_index), 64'(want.vertex_index));
          if (got.is_new !== want.is_new)
            report_mismatch("is_new", 64'(got.is_new), 64'(want.is_new));
          if (got.tri_valid !== want.tri_valid)
            report_mismatch("tri_valid", 64'(got.tri_valid), 64'(want.tri_valid));
          if (got.tri_first !== want.tri_first)
            report_mismatch("tri_first", 64'(got.tri_first), 64'(want.tri_first));
          if (got.tri_second !== want.tri_second)
            report_mismatch("tri_second", 64'(got.tri_second), 64'(want.tri_second));
          if (got.tri_third !== want.tri_third)
            report_mismatch("tri_third", 64'(got.tri_third), 64'(want.tri_third));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
        end
      end
    end
  end

  // Receiver back-pressure in random bursts while stalls are enabled
  initial out_if.ready = 1'b0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 99) < 15) begin
      stall_left = $urandom_range(0, 12);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Offer one vertex, after an optional idle burst, and hold it until accepted
  task automatic push_vertex(input vertex_t v, input logic typed, input weld_result_t res);
    stim_tag_t tag;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    tag = '{typed, res};
    stim_tags.insert(stim_tags.size(), tag);
    in_if.valid      <= 1'b1;
    in_if.mesh_start <= v.mesh_start;
    in_if.coord_x    <= v.pos[2];
    in_if.coord_y    <= v.pos[1];
    in_if.coord_z    <= v.pos[0];
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drop valid and wait until every outstanding result has arrived
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (stim_tags.size() != 0 || awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic strip, input logic [TOL_W-1:0] tol);
    drain_results();
    write_reg(ADDR_STRIP, APB_DATA_W'(strip));
    write_reg(ADDR_TOL, APB_DATA_W'(tol));
    drv_strip = strip;
    drv_tol   = tol;
  endtask

  initial begin
    vertex_t      v;
    weld_result_t res;
    coords_t      base;
    int           ph;
    int           row;
    int           sent;
    int           mesh_len;
    int           reuse_pct;
    int           i;
    int           axis;
    int           pick;
    int           sh;
    logic [COORD_W-1:0] jit;
    logic         strip;
    logic [TOL_W-1:0] tol;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mesh_start = 1'b0;
    in_if.coord_x    = '0;
    in_if.coord_y    = '0;
    in_if.coord_z    = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, reconfiguring between groups
    for (row = 0; row < $size(DIRECTED_ROWS); row++) begin
      if (DIRECTED_ROWS[row].strip != drv_strip || DIRECTED_ROWS[row].tol != drv_tol)
        apply_config(DIRECTED_ROWS[row].strip, DIRECTED_ROWS[row].tol);
      v.mesh_start = DIRECTED_ROWS[row].mesh_start;
      v.pos = {DIRECTED_ROWS[row].x, DIRECTED_ROWS[row].y, DIRECTED_ROWS[row].z};
      res = '0;
      res.vertex_index = DIRECTED_ROWS[row].exp_index;
      res.is_new       = DIRECTED_ROWS[row].exp_new;
      push_vertex(v, DIRECTED_ROWS[row].typed, res);
    end

    // Random phases of meshes, each under its own register setting
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin strip = 1'b1; tol = TOL_MAX; end
        1: begin strip = 1'b0; tol = '0; end
        2: begin strip = 1'b1; tol = '0; end
        default: begin
          strip = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 4))
            0: tol = '0;
            1: tol = TOL_RESET;
            2: tol = TOL_MAX;
            3: tol = TOL_W'($urandom_range(1, 1 << 20));
            default: tol = {8'($urandom), 32'($urandom)};
          endcase
        end
      endcase
      apply_config(strip, tol);
      // Quiet stretches now and then, and none at all in the closing phase
      if (ph == RAND_PHASES - 1 || $urandom_range(0, 3) == 0) begin
        idle_pct = 0;
        stall_on = 1'b0;
      end else begin
        idle_pct = $urandom_range(10, 40);
        stall_on = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short meshes; now and then one that runs past a full table
        if ($urandom_range(0, 9) == 0) begin
          mesh_len  = $urandom_range(TABLE_DEPTH + 4, TABLE_DEPTH + 16);
          reuse_pct = 5;
        end else begin
          mesh_len  = $urandom_range(1, 16);
          reuse_pct = 40;
        end
        mesh_hist.delete();
        for (i = 0; i < mesh_len; i++) begin
          v.mesh_start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
          pick = $urandom_range(0, 99);
          if (mesh_hist.size() != 0 && pick < reuse_pct) begin
            // Revisit an earlier vertex, exactly or with jitter around the tolerance
            base = mesh_hist[$urandom_range(0, mesh_hist.size() - 1)];
            for (axis = 0; axis < 3; axis++) begin
              sh  = $urandom_range(0, 22);
              jit = $urandom & ((32'd1 << sh) - 32'd1);
              if (pick < reuse_pct / 3) v.pos[axis] = base[axis];
              else if ($urandom_range(0, 1)) v.pos[axis] = base[axis] + jit;
              else v.pos[axis] = base[axis] - jit;
            end
          end else if (pick < reuse_pct + 5) begin
            for (axis = 0; axis < 3; axis++)
              case ($urandom_range(0, 3))
                0: v.pos[axis] = 32'h7FFF_FFFF;
                1: v.pos[axis] = 32'h8000_0000;
                2: v.pos[axis] = 32'h0000_0000;
                default: v.pos[axis] = 32'hFFFF_FFFF;
              endcase
          end else if (pick < reuse_pct + 25 && mesh_len <= 16) begin
            for (axis = 0; axis < 3; axis++)
              v.pos[axis] = 32'(int'($urandom_range(0, 4194303)) - 2097152);
          end else begin
            for (axis = 0; axis < 3; axis++)
              v.pos[axis] = $urandom;
          end
          mesh_hist.insert(mesh_hist.size(), v.pos);
          push_vertex(v, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 64'(awaited_results.size()), 64'd0);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #1000000;
    $display("testbench failed");
    $finish;
  end

endmodule

`default_nettype wire
